### rtl/core/gnd_pkg.sv
`timescale 1ns / 1ps
// gnd_pkg: shared constants for the gradient noise pipeline
// holds the lattice permutation table, the stage count and the scale reset value
package gnd_pkg;

  localparam int NSTG = 10;
  localparam logic [15:0] SCALE_RESET = 16'd63570;

  localparam logic [7:0] PERM_TABLE [256] = '{
    8'd63, 8'd9, 8'd212, 8'd205, 8'd31, 8'd128, 8'd72, 8'd59, 8'd137, 8'd203, 8'd195, 8'd170,
    8'd181, 8'd115, 8'd165, 8'd40, 8'd116, 8'd139, 8'd175, 8'd225, 8'd132, 8'd99, 8'd222,
    8'd2, 8'd41, 8'd15, 8'd197, 8'd93, 8'd169, 8'd90, 8'd228, 8'd43, 8'd221, 8'd38, 8'd206,
    8'd204, 8'd73, 8'd17, 8'd97, 8'd10, 8'd96, 8'd47, 8'd32, 8'd138, 8'd136, 8'd30, 8'd219,
    8'd78, 8'd224, 8'd13, 8'd193, 8'd88, 8'd134, 8'd211, 8'd7, 8'd112, 8'd176, 8'd19, 8'd106,
    8'd83, 8'd75, 8'd217, 8'd85, 8'd0, 8'd98, 8'd140, 8'd229, 8'd80, 8'd118, 8'd151, 8'd117,
    8'd251, 8'd103, 8'd242, 8'd81, 8'd238, 8'd172, 8'd82, 8'd110, 8'd4, 8'd227, 8'd77, 8'd243,
    8'd46, 8'd12, 8'd189, 8'd34, 8'd188, 8'd200, 8'd161, 8'd68, 8'd76, 8'd171, 8'd194, 8'd57,
    8'd48, 8'd247, 8'd233, 8'd51, 8'd105, 8'd5, 8'd23, 8'd42, 8'd50, 8'd216, 8'd45, 8'd239,
    8'd148, 8'd249, 8'd84, 8'd70, 8'd125, 8'd108, 8'd241, 8'd62, 8'd66, 8'd64, 8'd240, 8'd173,
    8'd185, 8'd250, 8'd49, 8'd6, 8'd37, 8'd26, 8'd21, 8'd244, 8'd60, 8'd223, 8'd255, 8'd16,
    8'd145, 8'd27, 8'd109, 8'd58, 8'd102, 8'd142, 8'd253, 8'd120, 8'd149, 8'd160, 8'd124,
    8'd156, 8'd79, 8'd186, 8'd135, 8'd127, 8'd14, 8'd121, 8'd22, 8'd65, 8'd54, 8'd153, 8'd91,
    8'd213, 8'd174, 8'd24, 8'd252, 8'd131, 8'd192, 8'd190, 8'd202, 8'd208, 8'd35, 8'd94,
    8'd231, 8'd56, 8'd95, 8'd183, 8'd163, 8'd111, 8'd147, 8'd25, 8'd67, 8'd36, 8'd92, 8'd236,
    8'd71, 8'd166, 8'd1, 8'd187, 8'd100, 8'd130, 8'd143, 8'd237, 8'd178, 8'd158, 8'd104,
    8'd184, 8'd159, 8'd177, 8'd52, 8'd214, 8'd230, 8'd119, 8'd87, 8'd114, 8'd201, 8'd179,
    8'd198, 8'd3, 8'd248, 8'd182, 8'd39, 8'd11, 8'd152, 8'd196, 8'd113, 8'd20, 8'd232, 8'd69,
    8'd141, 8'd207, 8'd234, 8'd53, 8'd86, 8'd180, 8'd226, 8'd74, 8'd150, 8'd218, 8'd29,
    8'd133, 8'd8, 8'd44, 8'd123, 8'd28, 8'd146, 8'd89, 8'd101, 8'd154, 8'd220, 8'd126,
    8'd155, 8'd122, 8'd210, 8'd168, 8'd254, 8'd162, 8'd129, 8'd33, 8'd18, 8'd209, 8'd61,
    8'd191, 8'd199, 8'd157, 8'd245, 8'd55, 8'd164, 8'd167, 8'd215, 8'd246, 8'd144, 8'd107,
    8'd235
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_TABLE[idx];
  endfunction

endpackage

### rtl/core/gradient_noise_3d.sv
`timescale 1ns / 1ps
// gradient_noise_3d: top level of the 3d gradient noise pipeline
// instantiates gnd_hash, three gnd_fade lanes and gnd_interp; uses gnd_pkg
//
// usage:
//   input channel: in_valid_i with coord_x_i/y/z (signed fixed point, FRAC_BITS
//   fraction bits); an item is taken when in_valid_i is high and in_stall_o low
//   output channel: out_valid_o with noise_value_o (signed, OUT_FRAC_BITS
//   fraction bits, clamped to plus or minus 2^OUT_FRAC_BITS - 1 lsb); taken when out_stall_i is low
//   config channel: cfg_valid_i/cfg_ready_o/cfg_data_i write output_scale
//   (unsigned 0.16); cfg_ready_o is always high; write only while idle
// throughput: one item per cycle while the output is not stalled, set by the ten-stage
//   pipeline with at most one multiplier or table level per stage
// stall: each stage moves forward when it is empty or the next one moves,
//   so bubbles are squeezed out; in_stall_o rises only when all ten stages
//   hold items and the output is stalled
// reset: all valid bits clear, output_scale returns to 63570 (about 0.97)
module gradient_noise_3d import gnd_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] noise_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [NSTG-1:0]      v_q, v_d, en;
  logic [15:0]          scale_q;
  logic [3:0]           hash [8];
  logic [FRAC_BITS-1:0] fx, fy, fz;
  logic [FRAC_BITS:0]   u, v, w;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      scale_q <= SCALE_RESET;
    end else begin
      v_q <= v_d;
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign cfg_ready_o = 1'b1;

  gnd_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk_i  (clk_i),
    .en_i   (en[2:0]),
    .xi_i   (coord_x_i[FRAC_BITS +: 8]),
    .yi_i   (coord_y_i[FRAC_BITS +: 8]),
    .zi_i   (coord_z_i[FRAC_BITS +: 8]),
    .fx_i   (coord_x_i[FRAC_BITS-1:0]),
    .fy_i   (coord_y_i[FRAC_BITS-1:0]),
    .fz_i   (coord_z_i[FRAC_BITS-1:0]),
    .hash_o (hash),
    .fx_o   (fx),
    .fy_o   (fy),
    .fz_o   (fz)
  );

  gnd_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en[4:0]),
    .frac_i (coord_x_i[FRAC_BITS-1:0]),
    .fade_o (u)
  );

  gnd_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en[4:0]),
    .frac_i (coord_y_i[FRAC_BITS-1:0]),
    .fade_o (v)
  );

  gnd_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
    .clk_i  (clk_i),
    .en_i   (en[4:0]),
    .frac_i (coord_z_i[FRAC_BITS-1:0]),
    .fade_o (w)
  );

  gnd_interp #(
    .FRAC_BITS     (FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .en_i    (en[9:3]),
    .hash_i  (hash),
    .fx_i    (fx),
    .fy_i    (fy),
    .fz_i    (fz),
    .u_i     (u),
    .v_i     (v),
    .w_i     (w),
    .scale_i (scale_q),
    .noise_o (noise_value_o)
  );

  // input stall only when the whole pipeline is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // first stage fills only through an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) && !v_q[0] |=> !v_q[0])
    else $error("first stage valid without an accepted item");

  // a held output item keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled output item changed");

  // the count of items in flight changes by at most one per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(v_q) <= $countones($past(v_q)) + 1) &&
    ($countones(v_q) + 1 >= $countones($past(v_q))))
    else $error("items lost or created in the pipeline");

endmodule

### rtl/core/gnd_hash.sv
`timescale 1ns / 1ps
// gnd_hash: three-stage corner hash through the permutation table
// depends on gnd_pkg for the table; carries the cell fractions alongside
module gnd_hash import gnd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic [7:0]           xi_i,
  input  logic [7:0]           yi_i,
  input  logic [7:0]           zi_i,
  input  logic [FRAC_BITS-1:0] fx_i,
  input  logic [FRAC_BITS-1:0] fy_i,
  input  logic [FRAC_BITS-1:0] fz_i,
  output logic [3:0]           hash_o [8],
  output logic [FRAC_BITS-1:0] fx_o,
  output logic [FRAC_BITS-1:0] fy_o,
  output logic [FRAC_BITS-1:0] fz_o
);

  logic [7:0] a_q, b_q, z0_q;
  logic [7:0] aa_q, ab_q, ba_q, bb_q;
  logic [3:0] h_q [8];
  logic [FRAC_BITS-1:0] fx_q [3];
  logic [FRAC_BITS-1:0] fy_q [3];
  logic [FRAC_BITS-1:0] fz_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q     <= perm(xi_i) + yi_i;
      b_q     <= perm(xi_i + 8'd1) + yi_i;
      z0_q    <= zi_i;
      fx_q[0] <= fx_i;
      fy_q[0] <= fy_i;
      fz_q[0] <= fz_i;
    end
    if (en_i[1]) begin
      aa_q    <= perm(a_q) + z0_q;
      ab_q    <= perm(a_q + 8'd1) + z0_q;
      ba_q    <= perm(b_q) + z0_q;
      bb_q    <= perm(b_q + 8'd1) + z0_q;
      fx_q[1] <= fx_q[0];
      fy_q[1] <= fy_q[0];
      fz_q[1] <= fz_q[0];
    end
    if (en_i[2]) begin
      h_q[0]  <= 4'(perm(aa_q));
      h_q[1]  <= 4'(perm(ba_q));
      h_q[2]  <= 4'(perm(ab_q));
      h_q[3]  <= 4'(perm(bb_q));
      h_q[4]  <= 4'(perm(aa_q + 8'd1));
      h_q[5]  <= 4'(perm(ba_q + 8'd1));
      h_q[6]  <= 4'(perm(ab_q + 8'd1));
      h_q[7]  <= 4'(perm(bb_q + 8'd1));
      fx_q[2] <= fx_q[1];
      fy_q[2] <= fy_q[1];
      fz_q[2] <= fz_q[1];
    end
  end

  assign hash_o = h_q;
  assign fx_o   = fx_q[2];
  assign fy_o   = fy_q[2];
  assign fz_o   = fz_q[2];

endmodule

### rtl/core/gnd_fade.sv
`timescale 1ns / 1ps
// gnd_fade: quintic fade curve of one fraction, at most one multiply per stage
// five register stages; no package content used beyond the import
module gnd_fade import gnd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [4:0]           en_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic [FRAC_BITS:0]   fade_o
);

  localparam int TW = FRAC_BITS + 6;
  localparam int PW = FRAC_BITS + 1 + TW;
  localparam logic signed [TW-1:0] ONE = TW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [TW-1:0] K10 = TW'(64'sd10 <<< FRAC_BITS);
  localparam logic signed [TW-1:0] K15 = TW'(64'sd15 <<< FRAC_BITS);

  logic [FRAC_BITS-1:0]  f_q [4];
  logic signed [TW-1:0]  t_q [1:3];
  logic signed [TW-1:0]  t0, t4, tc;
  logic [FRAC_BITS:0]    fade_q;

  function automatic logic signed [TW-1:0] mul_floor(input logic [FRAC_BITS-1:0] f,
                                                    input logic signed [TW-1:0] t);
    logic signed [PW-1:0] p;
    p = $signed({1'b0, f}) * t;
    return TW'(p >>> FRAC_BITS);
  endfunction

  always_comb begin
    t0 = ($signed({6'b0, f_q[0]}) <<< 2) + ($signed({6'b0, f_q[0]}) <<< 1) - K15;
    t4 = mul_floor(f_q[3], t_q[3]);
    if (t4 < 0) begin
      tc = '0;
    end else if (t4 > ONE) begin
      tc = ONE;
    end else begin
      tc = t4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      f_q[0] <= frac_i;
    end
    if (en_i[1]) begin
      f_q[1] <= f_q[0];
      t_q[1] <= mul_floor(f_q[0], t0) + K10;
    end
    if (en_i[2]) begin
      f_q[2] <= f_q[1];
      t_q[2] <= mul_floor(f_q[1], t_q[1]);
    end
    if (en_i[3]) begin
      f_q[3] <= f_q[2];
      t_q[3] <= mul_floor(f_q[2], t_q[2]);
    end
    if (en_i[4]) begin
      fade_q <= tc[FRAC_BITS:0];
    end
  end

  assign fade_o = fade_q;

endmodule

### rtl/core/gnd_interp.sv
`timescale 1ns / 1ps
// gnd_interp: corner gradients, trilinear interpolation, scaling and clamping
// seven register stages fed by gnd_hash and gnd_fade; uses gnd_pkg
module gnd_interp import gnd_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                 clk_i,
  input  logic [6:0]           en_i,
  input  logic [3:0]           hash_i [8],
  input  logic [FRAC_BITS-1:0] fx_i,
  input  logic [FRAC_BITS-1:0] fy_i,
  input  logic [FRAC_BITS-1:0] fz_i,
  input  logic [FRAC_BITS:0]   u_i,
  input  logic [FRAC_BITS:0]   v_i,
  input  logic [FRAC_BITS:0]   w_i,
  input  logic [15:0]          scale_i,
  output logic [15:0]          noise_o
);

  localparam int G   = FRAC_BITS + 3;
  localparam int LPW = G + FRAC_BITS + 3;
  localparam int PW  = G + 17;
  localparam int SH  = FRAC_BITS + 16 - OUT_FRAC_BITS;
  localparam logic signed [G-1:0]  ONE = G'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [PW-1:0] RND = PW'(64'sd1 <<< (SH - 1));
  localparam logic signed [PW-1:0] LIM = PW'((64'sd1 <<< OUT_FRAC_BITS) - 64'sd1);

  logic signed [G-1:0]  x0, y0, z0, x1, y1, z1;
  logic signed [G-1:0]  g_q [8];
  logic signed [G-1:0]  g2_q [8];
  logic signed [G-1:0]  l_q [4];
  logic signed [G-1:0]  m_q [2];
  logic signed [G-1:0]  n_q;
  logic [FRAC_BITS:0]   v5_q, w5_q, w6_q;
  logic signed [PW-1:0] p_q, r, rc;
  logic [15:0]          noise_q;

  function automatic logic signed [G-1:0] grad(input logic [3:0] h,
                                               input logic signed [G-1:0] x,
                                               input logic signed [G-1:0] y,
                                               input logic signed [G-1:0] z);
    logic signed [G-1:0] s;
    case (h)
      4'd0:    s = x + z;
      4'd1:    s = x + y;
      4'd2:    s = y + z;
      4'd3:    s = y - x;
      4'd4:    s = z - x;
      4'd5:    s = -x - y;
      4'd6:    s = z - y;
      4'd7:    s = x - y;
      4'd8:    s = x - z;
      4'd9:    s = y - z;
      4'd10:   s = -x - z;
      4'd11:   s = -y - z;
      4'd12:   s = x + y;
      4'd13:   s = y - x;
      4'd14:   s = z - y;
      default: s = -y - z;
    endcase
    return s;
  endfunction

  function automatic logic signed [G-1:0] lerp(input logic signed [G-1:0] a,
                                               input logic signed [G-1:0] b,
                                               input logic [FRAC_BITS:0] t);
    logic signed [G:0]     d;
    logic signed [LPW-1:0] p;
    d = {b[G-1], b} - {a[G-1], a};
    p = d * $signed({1'b0, t});
    return a + G'(p >>> FRAC_BITS);
  endfunction

  always_comb begin
    x0 = $signed({3'b0, fx_i});
    y0 = $signed({3'b0, fy_i});
    z0 = $signed({3'b0, fz_i});
    x1 = x0 - ONE;
    y1 = y0 - ONE;
    z1 = z0 - ONE;
    r  = (p_q + RND) >>> SH;
    if (r > LIM) begin
      rc = LIM;
    end else if (r < -LIM) begin
      rc = -LIM;
    end else begin
      rc = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      g_q[0] <= grad(hash_i[0], x0, y0, z0);
      g_q[1] <= grad(hash_i[1], x1, y0, z0);
      g_q[2] <= grad(hash_i[2], x0, y1, z0);
      g_q[3] <= grad(hash_i[3], x1, y1, z0);
      g_q[4] <= grad(hash_i[4], x0, y0, z1);
      g_q[5] <= grad(hash_i[5], x1, y0, z1);
      g_q[6] <= grad(hash_i[6], x0, y1, z1);
      g_q[7] <= grad(hash_i[7], x1, y1, z1);
    end
    if (en_i[1]) begin
      g2_q <= g_q;
    end
    if (en_i[2]) begin
      l_q[0] <= lerp(g2_q[0], g2_q[1], u_i);
      l_q[1] <= lerp(g2_q[2], g2_q[3], u_i);
      l_q[2] <= lerp(g2_q[4], g2_q[5], u_i);
      l_q[3] <= lerp(g2_q[6], g2_q[7], u_i);
      v5_q   <= v_i;
      w5_q   <= w_i;
    end
    if (en_i[3]) begin
      m_q[0] <= lerp(l_q[0], l_q[1], v5_q);
      m_q[1] <= lerp(l_q[2], l_q[3], v5_q);
      w6_q   <= w5_q;
    end
    if (en_i[4]) begin
      n_q <= lerp(m_q[0], m_q[1], w6_q);
    end
    if (en_i[5]) begin
      p_q <= n_q * $signed({1'b0, scale_i});
    end
    if (en_i[6]) begin
      noise_q <= rc[15:0];
    end
  end

  assign noise_o = noise_q;

endmodule

### tb/gradient_noise_3d_checker.sv
`timescale 1ns / 1ps
// gradient_noise_3d_checker: watches the point and noise channels of gradient_noise_3d,
// computes the expected noise for each accepted point and compares; uses gnd_pkg
module gradient_noise_3d_checker import gnd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] noise_value_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          noise_cnt_o
);

  localparam int FB = 16;
  localparam int OFB = 15;
  localparam longint ONE = 64'sd1 <<< FB;

  logic [15:0] scale_q;
  logic [15:0] noise_q[$];

  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint smooth(input longint f);
    longint t;
    t = 6 * f - 15 * ONE;
    t = fshr(f * t, FB) + 10 * ONE;
    t = fshr(f * t, FB);
    t = fshr(f * t, FB);
    t = fshr(f * t, FB);
    if (t < 0) t = 0;
    if (t > ONE) t = ONE;
    return t;
  endfunction

  function automatic longint corner(input logic [7:0] h, input longint x, input longint y,
                                    input longint z);
    case (h[3:0])
      4'd0: return x + z;
      4'd1: return x + y;
      4'd2: return y + z;
      4'd3: return -x + y;
      4'd4: return -x + z;
      4'd5: return -x - y;
      4'd6: return -y + z;
      4'd7: return x - y;
      4'd8: return x - z;
      4'd9: return y - z;
      4'd10: return -x - z;
      4'd11: return -y - z;
      4'd12: return x + y;
      4'd13: return -x + y;
      4'd14: return -y + z;
      default: return -y - z;
    endcase
  endfunction

  function automatic longint mix(input longint a, input longint b, input longint t);
    return a + fshr((b - a) * t, FB);
  endfunction

  function automatic logic [15:0] noise_at(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz, input logic [15:0] scl);
    logic [7:0] xi, yi, zi, a, b, aa, ab, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, n0, n1, n, p, lim;
    xi = px[23:16]; yi = py[23:16]; zi = pz[23:16];
    x = longint'(px[15:0]); y = longint'(py[15:0]); z = longint'(pz[15:0]);
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    a = PERM_TABLE[xi] + yi;
    aa = PERM_TABLE[a] + zi;
    ab = PERM_TABLE[8'(a + 1)] + zi;
    b = PERM_TABLE[8'(xi + 1)] + yi;
    ba = PERM_TABLE[b] + zi;
    bb = PERM_TABLE[8'(b + 1)] + zi;
    u = smooth(x); v = smooth(y); w = smooth(z);
    n0 = mix(mix(corner(PERM_TABLE[aa], x, y, z), corner(PERM_TABLE[ba], x1, y, z), u),
             mix(corner(PERM_TABLE[ab], x, y1, z), corner(PERM_TABLE[bb], x1, y1, z), u), v);
    n1 = mix(mix(corner(PERM_TABLE[8'(aa + 1)], x, y, z1),
                 corner(PERM_TABLE[8'(ba + 1)], x1, y, z1), u),
             mix(corner(PERM_TABLE[8'(ab + 1)], x, y1, z1),
                 corner(PERM_TABLE[8'(bb + 1)], x1, y1, z1), u), v);
    n = mix(n0, n1, w);
    p = n * longint'(scl);
    p = fshr(p + (64'sd1 <<< (FB + 16 - OFB - 1)), FB + 16 - OFB);
    lim = (64'sd1 <<< OFB) - 1;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return p[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      noise_q.delete();
      fail_cnt_o <= 0;
      noise_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) scale_q <= cfg_data_i;
      if (in_valid_i && !in_stall_i)
        noise_q.push_back(noise_at(coord_x_i, coord_y_i, coord_z_i, scale_q));
      if (out_valid_i && !out_stall_i) begin
        noise_cnt_o <= noise_cnt_o + 1;
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected noise item, actual %0d", $time, $signed(noise_value_i));
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = noise_q.pop_front();
          if (want !== noise_value_i) begin
            $display("%0t: noise_value expected %0d actual %0d", $time, $signed(want),
                     $signed(noise_value_i));
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      pending_o <= noise_q.size();
    end
  end

endmodule

### tb/gradient_noise_3d_tb.sv
`timescale 1ns / 1ps
// gradient_noise_3d_tb: stimulus and verdict for gradient_noise_3d over several scales
// depends on gnd_pkg, gradient_noise_3d and gradient_noise_3d_checker
module gradient_noise_3d_tb;

  localparam int IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] noise_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  int fail_cnt, pending, noise_cnt, idle_cyc, point_cnt;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  gradient_noise_3d dut (.*);

  gradient_noise_3d_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .coord_x_i, .coord_y_i,
    .coord_z_i, .out_valid_i(out_valid_o), .out_stall_i, .noise_value_i(noise_value_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i, .fail_cnt_o(fail_cnt),
    .pending_o(pending), .noise_cnt_o(noise_cnt)
  );

  // receiver stalls for a random time after each accepted item, sometimes not at all
  always @(posedge clk_i) begin
    int gap;
    if (out_valid_o && !out_stall_i) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("timeout with %0d noise items outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i <= px;
    coord_y_i <= py;
    coord_z_i <= pz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    point_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (gnd_pkg::NSTG + 4) @(posedge clk_i);
  endtask

  task automatic set_scale(input logic [15:0] s);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= s;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} | ($urandom_range(0, 1) ? 32'hFFFF0000 : 0);
      2: return {8'($urandom()), 8'($urandom_range(0, 2) == 0 ? 8'hFF : 8'h00),
                 16'($urandom())};
      3: return {16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000), 16'($urandom())};
      4: return {$urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 16'($urandom_range(0, 3))};
      default: return {16'($urandom()), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
    endcase
  endfunction

  initial begin
    logic [15:0] scales [5] = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd63570};
    logic [31:0] corners [8] = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                 32'h00008000, 32'h0000FFFF, 32'h00FF0000, 32'hFFFF0001};
    point_cnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset scale first, extreme coordinates and fractions
    for (int i = 0; i < 8; i++) send_point(corners[i], corners[(i + 3) % 8], corners[7 - i]);
    for (int i = 0; i < 16; i++) send_point({8'h0, 8'(i), 16'($urandom())},
                                            32'h00FF8000, {8'hFF, 8'(255 - i), 16'h4000});
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_scale(ph == 4 ? 16'($urandom()) : scales[ph]);
      for (int i = 0; i < 205; i++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    set_scale(16'd63570);
    $display("sent %0d points over six scale settings including 0 and 0xffff", point_cnt);
    $display("checked %0d noise items, %0d mismatches", noise_cnt, fail_cnt);
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/gnd_pkg.sv
rtl/core/gnd_hash.sv
rtl/core/gnd_fade.sv
rtl/core/gnd_interp.sv
rtl/core/gradient_noise_3d.sv
tb/gradient_noise_3d_checker.sv
tb/gradient_noise_3d_tb.sv
